// File: rtl/group_bitmap_block_allocator_core_assert.svh
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef GROUP_BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define GROUP_BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("allocator assertion failed");
`define GBBA_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("allocator forbidden condition seen");
`else
`define GBBA_ASSERT(lbl, clk, rst, prop)
`define GBBA_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/gbba_pkg.sv
`timescale 1ns / 1ps
package gbba_pkg;

   localparam int NUM_GROUPS_DEF = 16;
   localparam int GROUP_BITS_DEF = 8192;

   localparam int WORD_W   = 64;
   localparam int TYPE_W   = 1;
   localparam int COUNT_W  = 16;
   localparam int BLOCK_W  = 17;
   localparam int RUN_W    = 14;
   localparam int STATUS_W = 2;
   localparam int BPG_W    = 14;
   localparam int GC_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [TYPE_W-1:0] REQ_ALLOC   = 1'b0;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BPG = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GC  = 2'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_RUN,
      ST_RUN_LD,
      ST_DIV,
      ST_REL_RD,
      ST_REL_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               done;
      logic [BLOCK_W-1:0] quotient;
      logic [BPG_W-1:0]   remainder;
   } div_res_type;

endpackage

// File: rtl/gbba_if.sv
`timescale 1ns / 1ps
interface gbba_req_if;
   import gbba_pkg::*;
   logic               valid;
   logic               ready;
   logic [TYPE_W-1:0]  req_type;
   logic [COUNT_W-1:0] requested_count;
   logic [BLOCK_W-1:0] block_number;
   modport source (output valid, req_type, requested_count, block_number, input ready);
   modport sink (input valid, req_type, requested_count, block_number, output ready);
endinterface

interface gbba_rsp_if;
   import gbba_pkg::*;
   logic                valid;
   logic                ready;
   logic [BLOCK_W-1:0]  start_block;
   logic [RUN_W-1:0]    run_length;
   logic [STATUS_W-1:0] status;
   modport source (output valid, start_block, run_length, status, input ready);
   modport sink (input valid, start_block, run_length, status, output ready);
endinterface

// File: rtl/group_bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
// First-fit block allocator over a grouped used/free bitmap.
// Requests arrive on req_chan as valid/ready transfers. An allocate request
// (req_type 0) searches the groups in ascending order, one 64-bit bitmap word
// per cycle, takes the lowest free bit and then extends the run one bit per
// cycle, pausing to read the next word at each word boundary, until the
// requested count is met, a used bit is found or the group ends. A release
// request (req_type 1) splits the block number into group and offset with a
// serial divider and clears one bit by read-modify-write. Each request gives
// one response transfer on rsp_chan. The sequencer works on one request at a
// time.
// After reset the bitmap is swept to all used, one word per cycle, and
// req_chan.ready stays low meanwhile.
// Configuration writes on the csr_ port are taken at any time, but should be
// made only while the block is idle. The response sits in an output register,
// so a new request is taken while a stalled response waits; the next response
// is held back until the earlier one has been transferred.
// GROUP_BITS must be a multiple of 64.
`include "group_bitmap_block_allocator_core_assert.svh"
module group_bitmap_block_allocator_core #(
   parameter int NUM_GROUPS = gbba_pkg::NUM_GROUPS_DEF,
   parameter int GROUP_BITS = gbba_pkg::GROUP_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   gbba_req_if.sink                      req_chan,
   gbba_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [gbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbba_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gbba_pkg::*;

   localparam int WPG   = GROUP_BITS / WORD_W;
   localparam int DEPTH = NUM_GROUPS * WPG;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WI_W  = (WPG > 1) ? $clog2(WPG) : 1;
   localparam int GI_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int GRP_W = $clog2(NUM_GROUPS + 1);

   state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [BPG_W-1:0]    bpg_ff, bpg_in;
   logic [GC_W-1:0]     gc_ff, gc_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [GI_W-1:0]     g_ff, g_in;
   logic [WI_W-1:0]     w_ff, w_in;
   logic [5:0]          pos_ff, pos_in;
   logic [BPG_W-1:0]    b_ff, b_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [BLOCK_W-1:0]  start_ff, start_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [RUN_W-1:0]    rsp_run_ff, rsp_run_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [BPG_W-1:0]  ebpg;
   logic [GRP_W-1:0]  egroups;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic              div_start;
   div_res_type       div_res;
   logic              accept;
   logic [WORD_W-1:0] valid_mask, free_bits;
   logic [5:0]        free_pos;
   logic [31:0]       wbase;
   logic              last_word;
   logic [GRP_W-1:0]  g_next;
   logic [BPG_W:0]    b_next;
   logic [AW-1:0]     cur_addr;

   function automatic logic [AW-1:0] word_addr(input logic [GI_W-1:0] g,
                                                input logic [WI_W-1:0] w);
      return AW'(32'(g) * WPG + 32'(w));
   endfunction

   // Saturated register views.
   always_comb begin
      ebpg = bpg_ff;
      if (bpg_ff == '0) begin
         ebpg = BPG_W'(1);
      end else if (32'(bpg_ff) > GROUP_BITS) begin
         ebpg = BPG_W'(GROUP_BITS);
      end
      egroups = (32'(gc_ff) > NUM_GROUPS) ? GRP_W'(NUM_GROUPS) : GRP_W'(gc_ff);
   end

   // Free bits of the word just read, with bits past the group's end as used.
   // A last word that the group fills completely keeps all of its bits.
   always_comb begin
      wbase      = 32'(w_ff) * WORD_W;
      last_word  = (wbase + WORD_W) >= 32'(ebpg);
      valid_mask = {WORD_W{1'b1}};
      if ((wbase + WORD_W) > 32'(ebpg)) begin
         valid_mask = ~({WORD_W{1'b1}} << 6'(32'(ebpg) - wbase));
      end
      free_bits = ~ram_rdata & valid_mask;
      free_pos  = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_pos = 6'(i);
         end
      end
   end

   assign g_next   = GRP_W'(g_ff) + 1'b1;
   assign b_next   = {1'b0, b_ff} + 1'b1;
   assign cur_addr = word_addr(g_ff, w_ff);
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      bpg_in = bpg_ff;
      gc_in  = gc_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BPG: bpg_in = csr_wdata[BPG_W-1:0];
            CSR_GC:  gc_in  = csr_wdata[GC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      g_in          = g_ff;
      w_in          = w_ff;
      pos_in        = pos_ff;
      b_in          = b_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      status_in     = status_ff;
      word_in       = word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_start_in  = rsp_start_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_addr;
      ram_wdata     = word_ff;
      ram_raddr     = cur_addr;
      div_start     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {WORD_W{1'b1}};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               start_in  = '0;
               run_in    = '0;
               status_in = STAT_OK;
               cnt_in    = req_chan.requested_count;
               g_in      = '0;
               w_in      = '0;
               if (req_chan.req_type == REQ_RELEASE) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else if (req_chan.requested_count == '0) begin
                  state_in = ST_RESP;
               end else if (egroups == '0) begin
                  status_in = STAT_NOSPACE;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            if (free_bits != '0) begin
               pos_in   = free_pos;
               b_in     = BPG_W'(wbase + 32'(free_pos));
               word_in  = ram_rdata | (WORD_W'(1) << free_pos);
               cnt_in   = cnt_ff - 1'b1;
               run_in   = RUN_W'(1);
               start_in = BLOCK_W'(32'(ebpg) * 32'(g_ff) + wbase + 32'(free_pos));
               state_in = ST_RUN;
            end else if (last_word) begin
               if (g_next >= egroups) begin
                  status_in = STAT_NOSPACE;
                  state_in  = ST_RESP;
               end else begin
                  g_in      = g_next[GI_W-1:0];
                  w_in      = '0;
                  ram_raddr = word_addr(g_next[GI_W-1:0], '0);
               end
            end else begin
               w_in      = w_ff + 1'b1;
               ram_raddr = word_addr(g_ff, w_ff + 1'b1);
            end
         end
         ST_RUN: begin
            if (cnt_ff == '0 || b_next >= {1'b0, ebpg}) begin
               ram_we   = 1'b1;
               state_in = ST_RESP;
            end else if (pos_ff == 6'(WORD_W - 1)) begin
               ram_we    = 1'b1;
               w_in      = w_ff + 1'b1;
               ram_raddr = word_addr(g_ff, w_ff + 1'b1);
               state_in  = ST_RUN_LD;
            end else if (word_ff[pos_ff + 1'b1]) begin
               ram_we   = 1'b1;
               state_in = ST_RESP;
            end else begin
               word_in = word_ff | (WORD_W'(1) << (pos_ff + 1'b1));
               pos_in  = pos_ff + 1'b1;
               b_in    = b_next[BPG_W-1:0];
               cnt_in  = cnt_ff - 1'b1;
               run_in  = run_ff + 1'b1;
            end
         end
         ST_RUN_LD: begin
            // First bit of the following word continues the run if it is free.
            if (ram_rdata[0]) begin
               state_in = ST_RESP;
            end else begin
               word_in  = ram_rdata | WORD_W'(1);
               pos_in   = '0;
               b_in     = b_next[BPG_W-1:0];
               cnt_in   = cnt_ff - 1'b1;
               run_in   = run_ff + 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               if (div_res.quotient >= BLOCK_W'(egroups)) begin
                  status_in = STAT_RANGE;
                  state_in  = ST_RESP;
               end else begin
                  g_in     = div_res.quotient[GI_W-1:0];
                  w_in     = WI_W'(div_res.remainder >> 6);
                  b_in     = div_res.remainder;
                  state_in = ST_REL_RD;
               end
            end
         end
         ST_REL_RD: begin
            state_in = ST_REL_WR;
         end
         ST_REL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(WORD_W'(1) << b_ff[5:0]);
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = start_ff;
               rsp_run_in    = run_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bpg_ff       <= BPG_W'(8192);
         gc_ff        <= GC_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bpg_ff       <= bpg_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      g_ff          <= g_in;
      w_ff          <= w_in;
      pos_ff        <= pos_in;
      b_ff          <= b_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      status_ff     <= status_in;
      word_ff       <= word_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_status_ff <= rsp_status_in;
   end

   gbba_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_bitmap (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   gbba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(req_chan.block_number),
      .divisor (ebpg),
      .res     (div_res)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.start_block = rsp_start_ff;
   assign rsp_chan.run_length  = rsp_run_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // A run in progress always holds at least its first block.
   `GBBA_ASSERT(a_run_nonzero, clock, reset, (state_ff == ST_RUN) |-> (run_ff != '0))
   // The divider only finishes while the sequencer waits for it.
   `GBBA_ASSERT(a_div_done_state, clock, reset, div_res.done |-> (state_ff == ST_DIV))
   // No request is taken during the clearing sweep.
   `GBBA_NEVER(a_no_accept_clear, clock, reset, (state_ff == ST_CLEAR) && req_chan.ready)
endmodule

// File: rtl/gbba_ram.sv
`timescale 1ns / 1ps
module gbba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/gbba_div.sv
`timescale 1ns / 1ps
module gbba_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gbba_pkg::BLOCK_W-1:0] dividend,
   input  logic [gbba_pkg::BPG_W-1:0]   divisor,
   output gbba_pkg::div_res_type        res
);
   import gbba_pkg::*;
   localparam int CNT_W = $clog2(BLOCK_W + 1);

   logic [BLOCK_W-1:0] quo_ff, quo_in;
   logic [BPG_W-1:0]   rem_ff, rem_in;
   logic [BPG_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BPG_W:0]     trial;

   // One restoring step per cycle, most significant dividend bit first.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[BLOCK_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = BPG_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[BLOCK_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BPG_W-1:0];
            quo_in = {quo_ff[BLOCK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(BLOCK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;
endmodule
